[sv/vbs3d_pkg.sv]
// Shared constants, types and helper functions of the 3D box-sum filter.
package vbs3d_pkg;

    localparam int MAX_DIM_Y  = 64;
    localparam int MAX_DIM_Z  = 64;
    localparam int MAX_RADIUS = 7;
    localparam int VOXEL_BITS = 16;

    localparam int VOXEL_W   = 16;
    localparam int XW        = 16;
    localparam int YW        = 6;
    localparam int ZW        = 6;
    localparam int DIM_W     = 7;
    localparam int RAD_W     = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int ZSUM_W = 20;
    localparam int YSUM_W = 24;
    localparam int XSUM_W = 28;

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int RING_W = $clog2(RING);
    localparam int WIN_W  = $clog2(2 * MAX_RADIUS + 2);

    localparam int LINE_AW  = RING_W + ZW;
    localparam int PLANE_AW = RING_W + YW + ZW;
    localparam int XRS_AW   = YW + ZW;

    localparam logic [VOXEL_W-1:0] VOXEL_MASK = VOXEL_W'((33'd1 << VOXEL_BITS) - 33'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_X    = 3'd0,
        REG_DIM_Y    = 3'd1,
        REG_DIM_Z    = 3'd2,
        REG_RADIUS_X = 3'd3,
        REG_RADIUS_Y = 3'd4,
        REG_RADIUS_Z = 3'd5
    } cfg_reg_t;

    typedef logic [VOXEL_W-1:0] voxel_t;
    typedef logic [XSUM_W-1:0]  box_sum_t;
    typedef logic [XW-1:0]      coord_x_t;
    typedef logic [YW-1:0]      coord_y_t;
    typedef logic [ZW-1:0]      coord_z_t;

    typedef struct packed {
        box_sum_t box_sum;
        coord_x_t center_x;
        coord_y_t center_y;
        coord_z_t center_z;
    } result_t;

    // zero acts as one, oversized values clamp to the cap
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int cap);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > DIM_W'(cap))
            res = DIM_W'(cap);
        else
            res = v;
        return res;
    endfunction

    function automatic logic [RAD_W-1:0] eff_rad(input logic [RAD_W-1:0] r);
        logic [RAD_W-1:0] res;
        res = (r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r;
        return res;
    endfunction

    // box width 2r+1
    function automatic logic [WIN_W-1:0] win(input logic [RAD_W-1:0] r);
        return WIN_W'({r, 1'b1});
    endfunction

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] a);
        logic [RING_W-1:0] res;
        res = (a == RING_W'(RING - 1)) ? '0 : a + RING_W'(1);
        return res;
    endfunction

    // (a - w) mod RING for a below RING and w up to RING
    function automatic logic [RING_W-1:0] ring_sub(input logic [RING_W-1:0] a,
                                                   input logic [WIN_W-1:0]  w);
        logic [RING_W+1:0] sum;
        sum = (RING_W+2)'(a) + (RING_W+2)'(RING) - (RING_W+2)'(w);
        if (sum >= (RING_W+2)'(RING))
            sum = sum - (RING_W+2)'(RING);
        return sum[RING_W-1:0];
    endfunction

endpackage

[sv/vbs3d_if.sv]
// Stream interfaces for the voxel input and the box-sum results.
interface vbs3d_voxel_if;
    import vbs3d_pkg::*;
    logic   valid;
    logic   ready;
    voxel_t voxel;
    modport source (output valid, output voxel, input ready);
    modport sink   (input valid, input voxel, output ready);
endinterface

interface vbs3d_result_if;
    import vbs3d_pkg::*;
    logic     valid;
    logic     ready;
    box_sum_t box_sum;
    coord_x_t center_x;
    coord_y_t center_y;
    coord_z_t center_z;
    modport source (output valid, output box_sum, output center_x, output center_y,
                    output center_z, input ready);
    modport sink   (input valid, input box_sum, input center_x, input center_y,
                    input center_z, output ready);
endinterface

[sv/volume_box_sum_3d_core.sv]
// Streaming 3D box-sum filter: z window, line store, plane store, x running sums.
//
//  channel   dir  handshake        payload
//  voxels    in   valid/ready      voxel[15:0]
//  results   out  valid/ready      box_sum[27:0] center_x[15:0] center_y[5:0] center_z[5:0]
//  cfg       in   cfg_wr_en        cfg_index[2:0] cfg_data[15:0]
//
// One voxel per cycle. The voxel that closes a box goes through the read of the
// stores, the y update and the x update before its result enters the output queue.
// Each store is read once and written once per cycle; same-entry overlaps are
// forwarded from the last write. Stores need no clearing after reset.
// A two-entry output queue keeps input running while one result waits;
// the pipeline stalls only when that queue is full and not drained.
module volume_box_sum_3d_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [vbs3d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vbs3d_pkg::CFG_W-1:0]     cfg_data,
    vbs3d_voxel_if.sink                    voxels,
    vbs3d_result_if.source                 results
);
    import vbs3d_pkg::*;

    // configuration
    logic [XW-1:0]    dim_x_reg;
    logic [DIM_W-1:0] dim_y_reg;
    logic [DIM_W-1:0] dim_z_reg;
    logic [RAD_W-1:0] rad_x_reg;
    logic [RAD_W-1:0] rad_y_reg;
    logic [RAD_W-1:0] rad_z_reg;

    logic [XW-1:0]    dx;
    logic [DIM_W-1:0] dy;
    logic [DIM_W-1:0] dz;
    logic [RAD_W-1:0] rx;
    logic [RAD_W-1:0] ry;
    logic [RAD_W-1:0] rz;
    logic [WIN_W-1:0] wx;
    logic [WIN_W-1:0] wy;
    logic [WIN_W-1:0] wz;

    // position and z window
    logic [XW-1:0]     pos_x_reg;
    logic [YW-1:0]     pos_y_reg;
    logic [ZW-1:0]     pos_z_reg;
    logic [RING_W-1:0] yrow_reg;
    logic [RING_W-1:0] xpl_reg;
    logic [ZSUM_W-1:0] zrs_reg;
    logic [VOXEL_W-1:0] taps_reg [RING];

    // stores
    logic [YSUM_W-1:0] yrs_mem   [2**ZW];
    logic [ZSUM_W-1:0] line_mem  [2**LINE_AW];
    logic [YSUM_W-1:0] plane_mem [2**PLANE_AW];
    logic [XSUM_W-1:0] xrs_mem   [2**XRS_AW];

    logic [YSUM_W-1:0] yrs_rd_reg;
    logic [ZSUM_W-1:0] line_rd_reg;
    logic [YSUM_W-1:0] plane_rd_reg;
    logic [XSUM_W-1:0] xrs_rd_reg;

    // last-write forwarding
    logic              yrs_fw_valid_reg;
    logic [ZW-1:0]     yrs_fw_addr_reg;
    logic [YSUM_W-1:0] yrs_fw_data_reg;
    logic              line_fw_valid_reg;
    logic [LINE_AW-1:0] line_fw_addr_reg;
    logic [ZSUM_W-1:0] line_fw_data_reg;
    logic              plane_fw_valid_reg;
    logic [PLANE_AW-1:0] plane_fw_addr_reg;
    logic [YSUM_W-1:0] plane_fw_data_reg;
    logic              xrs_fw_valid_reg;
    logic [XRS_AW-1:0] xrs_fw_addr_reg;
    logic [XSUM_W-1:0] xrs_fw_data_reg;

    // stage 1
    logic              s1_valid_reg;
    logic [XW-1:0]     s1_x_reg;
    logic [YW-1:0]     s1_y_reg;
    logic [ZW-1:0]     s1_z_reg;
    logic [ZSUM_W-1:0] s1_zs_reg;
    logic [RING_W-1:0] s1_yrow_reg;
    logic [RING_W-1:0] s1_xpl_reg;
    logic [LINE_AW-1:0] s1_line_rd_addr_reg;
    logic [PLANE_AW-1:0] s1_plane_rd_addr_reg;
    logic              s1_y_zero_reg;
    logic              s1_y_ge_reg;
    logic              s1_x_zero_reg;
    logic              s1_x_ge_reg;
    logic              s1_hit_reg;

    // stage 2
    logic              s2_valid_reg;
    logic [XW-1:0]     s2_x_reg;
    logic [YW-1:0]     s2_y_reg;
    logic [ZW-1:0]     s2_z_reg;
    logic [YSUM_W-1:0] s2_ys_reg;
    logic [YSUM_W-1:0] s2_plane_reg;
    logic [XSUM_W-1:0] s2_xrs_reg;
    logic              s2_x_zero_reg;
    logic              s2_x_ge_reg;
    logic              s2_hit_reg;

    // output queue
    result_t     fifo_reg [2];
    logic        fifo_wr_ptr_reg;
    logic        fifo_rd_ptr_reg;
    logic [1:0]  fifo_cnt_reg;

    // control
    logic advance;
    logic accept;
    logic push;
    logic pop;

    // stage 0 combinational
    voxel_t            v;
    logic              z_first;
    logic              z_ge;
    logic              y_ge;
    logic              x_ge;
    logic              hit0;
    logic [VOXEL_W-1:0] tap;
    logic [ZSUM_W-1:0] zs_next;
    logic [RING_W-1:0] line_rd_row;
    logic [RING_W-1:0] plane_rd_pl;
    logic [LINE_AW-1:0] line_rd_addr0;
    logic [PLANE_AW-1:0] plane_rd_addr0;
    logic [XRS_AW-1:0] xrs_addr0;
    logic              z_last;
    logic              y_last;
    logic              x_last;

    // stage 1/2 combinational
    logic [LINE_AW-1:0]  s1_line_wr_addr;
    logic [PLANE_AW-1:0] s1_plane_wr_addr;
    logic [XRS_AW-1:0]   s1_xrs_addr;
    logic [XRS_AW-1:0]   s2_xrs_addr;
    logic [YSUM_W-1:0]   yrs_f;
    logic [ZSUM_W-1:0]   line_f;
    logic [YSUM_W-1:0]   plane_f;
    logic [XSUM_W-1:0]   xrs_f1;
    logic [XSUM_W-1:0]   xrs_f2;
    logic [YSUM_W-1:0]   ys;
    logic [XSUM_W-1:0]   xs;
    result_t             res_new;
    result_t             res_head;

    always_comb
    begin
        dx = (dim_x_reg == '0) ? XW'(1) : dim_x_reg;
        dy = eff_dim(dim_y_reg, MAX_DIM_Y);
        dz = eff_dim(dim_z_reg, MAX_DIM_Z);
        rx = eff_rad(rad_x_reg);
        ry = eff_rad(rad_y_reg);
        rz = eff_rad(rad_z_reg);
        wx = win(rx);
        wy = win(ry);
        wz = win(rz);
    end

    assign advance      = (fifo_cnt_reg != 2'd2) || results.ready;
    assign voxels.ready = advance;
    assign accept       = voxels.valid && advance;
    assign push         = advance && s2_valid_reg && s2_hit_reg;
    assign pop          = results.valid && results.ready;

    // stage 0: z window and store addresses
    always_comb
    begin
        v       = voxels.voxel & VOXEL_MASK;
        z_first = (pos_z_reg == '0);
        z_ge    = DIM_W'(pos_z_reg) >= DIM_W'(wz);
        y_ge    = DIM_W'(pos_y_reg) >= DIM_W'(wy);
        x_ge    = pos_x_reg >= XW'(wx);
        hit0    = (pos_x_reg >= XW'({rx, 1'b0}))
                  && (DIM_W'(pos_y_reg) >= DIM_W'({ry, 1'b0}))
                  && (DIM_W'(pos_z_reg) >= DIM_W'({rz, 1'b0}));
        tap     = taps_reg[RING_W'(wz - WIN_W'(1))];
        zs_next = (z_first ? '0 : zrs_reg) + ZSUM_W'(v) - (z_ge ? ZSUM_W'(tap) : '0);
        line_rd_row    = ring_sub(yrow_reg, wy);
        plane_rd_pl    = ring_sub(xpl_reg, wx);
        line_rd_addr0  = {line_rd_row, pos_z_reg};
        plane_rd_addr0 = {plane_rd_pl, pos_y_reg, pos_z_reg};
        xrs_addr0      = {pos_y_reg, pos_z_reg};
        z_last = (DIM_W'(pos_z_reg) + DIM_W'(1)) >= dz;
        y_last = (DIM_W'(pos_y_reg) + DIM_W'(1)) >= dy;
        x_last = ({1'b0, pos_x_reg} + (XW+1)'(1)) >= {1'b0, dx};
    end

    // configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= XW'(1);
            dim_y_reg <= DIM_W'(1);
            dim_z_reg <= DIM_W'(1);
            rad_x_reg <= '0;
            rad_y_reg <= '0;
            rad_z_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            yrow_reg  <= '0;
            xpl_reg   <= '0;
            zrs_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIM_X:    dim_x_reg <= cfg_data[XW-1:0];
                REG_DIM_Y:    dim_y_reg <= cfg_data[DIM_W-1:0];
                REG_DIM_Z:    dim_z_reg <= cfg_data[DIM_W-1:0];
                REG_RADIUS_X: rad_x_reg <= cfg_data[RAD_W-1:0];
                REG_RADIUS_Y: rad_y_reg <= cfg_data[RAD_W-1:0];
                REG_RADIUS_Z: rad_z_reg <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
            // any write starts a new volume
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            yrow_reg  <= '0;
            xpl_reg   <= '0;
        end
        else if (accept)
        begin
            zrs_reg <= zs_next;
            if (z_last)
            begin
                pos_z_reg <= '0;
                if (y_last)
                begin
                    pos_y_reg <= '0;
                    yrow_reg  <= '0;
                    if (x_last)
                    begin
                        pos_x_reg <= '0;
                        xpl_reg   <= '0;
                    end
                    else
                    begin
                        pos_x_reg <= pos_x_reg + XW'(1);
                        xpl_reg   <= ring_inc(xpl_reg);
                    end
                end
                else
                begin
                    pos_y_reg <= pos_y_reg + YW'(1);
                    yrow_reg  <= ring_inc(yrow_reg);
                end
            end
            else
            begin
                pos_z_reg <= pos_z_reg + ZW'(1);
            end
        end
    end

    // recent samples along z, newest at tap 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            taps_reg[0] <= v;
            for (int i = 1; i < RING; i++)
                taps_reg[i] <= taps_reg[i-1];
        end
    end

    // pipeline control and forwarding valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            yrs_fw_valid_reg   <= 1'b0;
            line_fw_valid_reg  <= 1'b0;
            plane_fw_valid_reg <= 1'b0;
            xrs_fw_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg       <= accept;
            s2_valid_reg       <= s1_valid_reg;
            yrs_fw_valid_reg   <= s1_valid_reg;
            line_fw_valid_reg  <= s1_valid_reg;
            plane_fw_valid_reg <= s1_valid_reg;
            xrs_fw_valid_reg   <= s2_valid_reg;
        end
    end

    // stage 1: y running sum
    always_comb
    begin
        s1_line_wr_addr  = {s1_yrow_reg, s1_z_reg};
        s1_plane_wr_addr = {s1_xpl_reg, s1_y_reg, s1_z_reg};
        s1_xrs_addr      = {s1_y_reg, s1_z_reg};
        yrs_f   = (yrs_fw_valid_reg && yrs_fw_addr_reg == s1_z_reg)
                  ? yrs_fw_data_reg : yrs_rd_reg;
        line_f  = (line_fw_valid_reg && line_fw_addr_reg == s1_line_rd_addr_reg)
                  ? line_fw_data_reg : line_rd_reg;
        plane_f = (plane_fw_valid_reg && plane_fw_addr_reg == s1_plane_rd_addr_reg)
                  ? plane_fw_data_reg : plane_rd_reg;
        xrs_f1  = (xrs_fw_valid_reg && xrs_fw_addr_reg == s1_xrs_addr)
                  ? xrs_fw_data_reg : xrs_rd_reg;
        ys = (s1_y_zero_reg ? '0 : yrs_f) + YSUM_W'(s1_zs_reg)
             - (s1_y_ge_reg ? YSUM_W'(line_f) : '0);
    end

    // stage 2: x running sum
    always_comb
    begin
        s2_xrs_addr = {s2_y_reg, s2_z_reg};
        xrs_f2 = (xrs_fw_valid_reg && xrs_fw_addr_reg == s2_xrs_addr)
                 ? xrs_fw_data_reg : s2_xrs_reg;
        xs = (s2_x_zero_reg ? '0 : xrs_f2) + XSUM_W'(s2_ys_reg)
             - (s2_x_ge_reg ? XSUM_W'(s2_plane_reg) : '0);
        res_new.box_sum  = xs;
        res_new.center_x = s2_x_reg - XW'(rx);
        res_new.center_y = s2_y_reg - YW'(ry);
        res_new.center_z = s2_z_reg - ZW'(rz);
    end

    // pipeline payload and forwarding data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg             <= pos_x_reg;
            s1_y_reg             <= pos_y_reg;
            s1_z_reg             <= pos_z_reg;
            s1_zs_reg            <= zs_next;
            s1_yrow_reg          <= yrow_reg;
            s1_xpl_reg           <= xpl_reg;
            s1_line_rd_addr_reg  <= line_rd_addr0;
            s1_plane_rd_addr_reg <= plane_rd_addr0;
            s1_y_zero_reg        <= (pos_y_reg == '0);
            s1_y_ge_reg          <= y_ge;
            s1_x_zero_reg        <= (pos_x_reg == '0);
            s1_x_ge_reg          <= x_ge;
            s1_hit_reg           <= hit0;

            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_z_reg      <= s1_z_reg;
            s2_ys_reg     <= ys;
            s2_plane_reg  <= plane_f;
            s2_xrs_reg    <= xrs_f1;
            s2_x_zero_reg <= s1_x_zero_reg;
            s2_x_ge_reg   <= s1_x_ge_reg;
            s2_hit_reg    <= s1_hit_reg;

            yrs_fw_addr_reg   <= s1_z_reg;
            yrs_fw_data_reg   <= ys;
            line_fw_addr_reg  <= s1_line_wr_addr;
            line_fw_data_reg  <= s1_zs_reg;
            plane_fw_addr_reg <= s1_plane_wr_addr;
            plane_fw_data_reg <= ys;
            xrs_fw_addr_reg   <= s2_xrs_addr;
            xrs_fw_data_reg   <= xs;
        end
    end

    // column y sums
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            yrs_rd_reg <= yrs_mem[pos_z_reg];
            if (s1_valid_reg)
                yrs_mem[s1_z_reg] <= ys;
        end
    end

    // line store of z sums
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_rd_reg <= line_mem[line_rd_addr0];
            if (s1_valid_reg)
                line_mem[s1_line_wr_addr] <= s1_zs_reg;
        end
    end

    // plane store of yz sums
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plane_rd_reg <= plane_mem[plane_rd_addr0];
            if (s1_valid_reg)
                plane_mem[s1_plane_wr_addr] <= ys;
        end
    end

    // x running sums per (y, z)
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xrs_rd_reg <= xrs_mem[xrs_addr0];
            if (s2_valid_reg)
                xrs_mem[s2_xrs_addr] <= xs;
        end
    end

    // output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
            fifo_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                fifo_wr_ptr_reg <= ~fifo_wr_ptr_reg;
            if (pop)
                fifo_rd_ptr_reg <= ~fifo_rd_ptr_reg;
            if (push && !pop)
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            else if (pop && !push)
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[fifo_wr_ptr_reg] <= res_new;
    end

    assign res_head         = fifo_reg[fifo_rd_ptr_reg];
    assign results.valid    = (fifo_cnt_reg != 2'd0);
    assign results.box_sum  = res_head.box_sum;
    assign results.center_x = res_head.center_x;
    assign results.center_y = res_head.center_y;
    assign results.center_z = res_head.center_z;

endmodule
